/* hdl/zr_pkg.sv */
// ----------------------------------------------------------------------------
// zr_pkg
// Shared types, constants and register codes of the ultrasonic zone ranger.
// ----------------------------------------------------------------------------
package zr_pkg;

   // Measurement shape
   localparam int SAMPLES = 30;
   localparam int SENSORS = 4;

   localparam int ROUND_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SENSOR_W = 2;
   localparam int TICK_W   = 16;
   localparam int SUM_W    = 15;
   localparam int AVG_W    = 10;

   // Distance in cm: (count / 2) / 58, done as a reciprocal multiply
   localparam int CM_SHIFT = 21;
   localparam logic [15:0] CM_RECIP = 16'd36158;
   localparam int CM_PROD_W = 31;

   // Average: sum / SAMPLES, done as a reciprocal multiply
   localparam int AVG_SHIFT = 26;
   localparam int AVG_RECIP_W = 27;
   localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
      AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);
   localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;
   localparam int AVG_Q_W    = AVG_PROD_W - AVG_SHIFT;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

   // Queue depths (powers of two)
   localparam int FRONT_DEPTH = 4;
   localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);

   // Zone codes
   localparam logic [1:0] ZONE_NEAR   = 2'd1;
   localparam logic [1:0] ZONE_MIDDLE = 2'd2;
   localparam logic [1:0] ZONE_CLEAR  = 2'd3;

   // Configuration reset values
   localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
   localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd5900;
   localparam logic [9:0]  NEAR_LIMIT_RST    = 10'd20;
   localparam logic [9:0]  FAR_LIMIT_RST     = 10'd40;

   typedef enum logic [1:0] {
      CSR_TRIGGER_TICKS = 2'd0,
      CSR_ECHO_TIMEOUT  = 2'd1,
      CSR_NEAR_LIMIT    = 2'd2,
      CSR_FAR_LIMIT     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_TRIG  = 2'd1,
      PH_WAIT  = 2'd2,
      PH_COUNT = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]  trigger_ticks;
      logic [15:0] echo_timeout;
      logic [9:0]  near_limit;
      logic [9:0]  far_limit;
   } cfg_type;

   // Classified input item
   typedef struct packed {
      logic       start;
      logic [3:0] echo;
   } req_item_type;

   // Per-item status that rides down the pipe
   typedef struct packed {
      logic [3:0] trigger_lines;
      logic       busy;
      logic       done;
   } ctrl_type;

   // Sequencer output stage
   typedef struct packed {
      logic                valid;
      ctrl_type            ctrl;
      logic                clear;
      logic                fin;
      logic [SENSOR_W-1:0] fin_idx;
      logic [TICK_W-1:0]   fin_count;
   } stage_type;

   typedef struct packed {
      logic [3:0]            trigger_lines;
      logic                  busy;
      logic                  result_valid;
      logic [1:0]            zone;
      logic [3:0][AVG_W-1:0] average;
   } rsp_item_type;

endpackage

/* hdl/ultrasonic_zone_ranger.sv */
// ----------------------------------------------------------------------------
// ultrasonic_zone_ranger
// Four-sensor ultrasonic ranging, averaged over a number of rounds, with a
// near / middle / clear zone decision. One result item per input item.
// Item path: sequencer stage, back end stages 2-5, result queue (empty low).
// Throughput: one item per cycle sustained; the sequencer pulls an item only
// when the 8-entry result queue has room for it and all (up to 5) in flight.
// Reset: control state, sums and averages clear, zone reads clear (3), and
// the registers take their default values; both queues come up empty.
// ----------------------------------------------------------------------------
module ultrasonic_zone_ranger (
   input  logic        clock,
   input  logic        reset,
   // input item queue
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic [3:0]  req_echo_levels,
   // result queue
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_trigger_lines,
   output logic        rsp_busy_res,
   output logic        rsp_result_valid,
   output logic [1:0]  rsp_zone_code,
   output logic [9:0]  rsp_average_a,
   output logic [9:0]  rsp_average_b,
   output logic [9:0]  rsp_average_c,
   output logic [9:0]  rsp_average_d,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   zr_pkg::cfg_type              cfg_ff;
   zr_pkg::req_item_type         item;
   logic                         item_valid;
   logic                         item_pop;
   logic                         issue_ok;
   zr_pkg::stage_type            stage;
   logic [2:0]                   back_inflight;
   logic                         rsp_push;
   zr_pkg::rsp_item_type         rsp_item;
   zr_pkg::rsp_item_type         head;
   logic [zr_pkg::RSP_PTR_W:0]   rsp_level;
   logic [zr_pkg::RSP_PTR_W+1:0] rsp_need;

   // Register file; writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= zr_pkg::TRIGGER_TICKS_RST;
         cfg_ff.echo_timeout  <= zr_pkg::ECHO_TIMEOUT_RST;
         cfg_ff.near_limit    <= zr_pkg::NEAR_LIMIT_RST;
         cfg_ff.far_limit     <= zr_pkg::FAR_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (zr_pkg::csr_index_type'(csr_index))
            zr_pkg::CSR_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr_wdata[7:0];
            zr_pkg::CSR_ECHO_TIMEOUT:  cfg_ff.echo_timeout  <= csr_wdata;
            zr_pkg::CSR_NEAR_LIMIT:    cfg_ff.near_limit    <= csr_wdata[9:0];
            zr_pkg::CSR_FAR_LIMIT:     cfg_ff.far_limit     <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // Issue only when every item in flight plus this one fits the result queue
   always_comb begin
      rsp_need = (zr_pkg::RSP_PTR_W+2)'(rsp_level)
               + (zr_pkg::RSP_PTR_W+2)'(back_inflight)
               + (zr_pkg::RSP_PTR_W+2)'(stage.valid)
               + (zr_pkg::RSP_PTR_W+2)'(1);
      issue_ok = (rsp_need <= (zr_pkg::RSP_PTR_W+2)'(zr_pkg::RSP_DEPTH));
   end

   zr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_echo_levels (req_echo_levels),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   zr_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .issue_ok   (issue_ok),
      .item_pop   (item_pop),
      .stage      (stage)
   );

   zr_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .stage    (stage),
      .inflight (back_inflight),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item)
   );

   zr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .pop       (pop),
      .empty     (empty),
      .head      (head),
      .level     (rsp_level)
   );

   // Drive the result ports from the queue head
   assign rsp_trigger_lines = head.trigger_lines;
   assign rsp_busy_res      = head.busy;
   assign rsp_result_valid  = head.result_valid;
   assign rsp_zone_code     = head.zone;
   assign rsp_average_a     = head.average[0];
   assign rsp_average_b     = head.average[1];
   assign rsp_average_c     = head.average[2];
   assign rsp_average_d     = head.average[3];

endmodule

/* hdl/zr_front.sv */
// ----------------------------------------------------------------------------
// zr_front
// Input queue: takes items from the port, tags start requests, holds them
// until the sequencer pulls them.
// ----------------------------------------------------------------------------
module zr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_type,
   input  logic [3:0]           req_echo_levels,
   output logic                 item_valid,
   output zr_pkg::req_item_type item,
   input  logic                 item_pop
);

   zr_pkg::req_item_type          entry_ff [zr_pkg::FRONT_DEPTH];
   logic [zr_pkg::FRONT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [zr_pkg::FRONT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [zr_pkg::FRONT_PTR_W:0]   count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;
   zr_pkg::req_item_type           new_item;

   assign full       = (count_ff == (zr_pkg::FRONT_PTR_W+1)'(zr_pkg::FRONT_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   // Classify: type 1 is a start request, anything else a tick
   always_comb begin
      new_item.start = req_type;
      new_item.echo  = req_echo_levels;
   end

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (zr_pkg::FRONT_PTR_W)'(do_push);
      rd_ptr_in = rd_ptr_ff + (zr_pkg::FRONT_PTR_W)'(do_pop);
      count_in  = count_ff + (zr_pkg::FRONT_PTR_W+1)'(do_push)
                           - (zr_pkg::FRONT_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hdl/zr_sequencer.sv */
// ----------------------------------------------------------------------------
// zr_sequencer
// Ranging state machine (trigger, echo wait, echo count per sensor): one item
// per cycle while issue_ok. Emits item status and the finished sensor counts.
// ----------------------------------------------------------------------------
module zr_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  zr_pkg::cfg_type      cfg,
   input  logic                 item_valid,
   input  zr_pkg::req_item_type item,
   input  logic                 issue_ok,
   output logic                 item_pop,
   output zr_pkg::stage_type    stage
);

   zr_pkg::phase_type                phase_ff, phase_in;
   logic [zr_pkg::SENSOR_W-1:0]      sensor_ff, sensor_in;
   logic [zr_pkg::ROUND_W-1:0]       round_ff, round_in;
   logic [zr_pkg::TICK_W-1:0]        tick_ff, tick_in;
   zr_pkg::stage_type                stage_ff, stage_in;

   logic [zr_pkg::TICK_W-1:0]        tick_inc;
   logic                             echo_bit;
   logic                             finish;
   logic [zr_pkg::TICK_W-1:0]        fin_count;
   logic                             done;
   logic                             clear;
   logic [zr_pkg::SENSOR_W:0]        sensor_nxt;
   logic [zr_pkg::ROUND_W:0]         round_nxt;

   assign item_pop = item_valid && issue_ok;
   assign stage    = stage_ff;

   // Next state for the item being pulled
   always_comb begin
      phase_in   = phase_ff;
      sensor_in  = sensor_ff;
      round_in   = round_ff;
      tick_in    = tick_ff;
      finish     = 1'b0;
      fin_count  = '0;
      done       = 1'b0;
      clear      = 1'b0;
      tick_inc   = tick_ff + 16'd1;
      echo_bit   = item.echo[sensor_ff];
      sensor_nxt = {1'b0, sensor_ff} + 3'd1;
      round_nxt  = {1'b0, round_ff} + (zr_pkg::ROUND_W+1)'(1);

      if (item_pop) begin
         if (item.start) begin
            // Start only from idle; ignored while busy
            if (phase_ff == zr_pkg::PH_IDLE) begin
               sensor_in = '0;
               round_in  = '0;
               tick_in   = '0;
               phase_in  = zr_pkg::PH_TRIG;
               clear     = 1'b1;
            end
         end else begin
            case (phase_ff)
               zr_pkg::PH_TRIG: begin
                  if (tick_inc >= {8'd0, cfg.trigger_ticks}) begin
                     tick_in  = '0;
                     phase_in = zr_pkg::PH_WAIT;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               zr_pkg::PH_WAIT: begin
                  if (echo_bit) begin
                     tick_in  = '0;
                     phase_in = zr_pkg::PH_COUNT;
                  end else if (tick_inc >= cfg.echo_timeout) begin
                     finish    = 1'b1;
                     fin_count = '0;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               zr_pkg::PH_COUNT: begin
                  if (!echo_bit) begin
                     finish    = 1'b1;
                     fin_count = tick_ff;
                  end else if (tick_inc >= cfg.echo_timeout) begin
                     finish    = 1'b1;
                     fin_count = tick_inc;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               default: begin
                  // idle: a tick changes nothing
               end
            endcase

            // Sensor done: move to next sensor, next round, or finish
            if (finish) begin
               tick_in = '0;
               if (sensor_nxt >= (zr_pkg::SENSOR_W+1)'(zr_pkg::SENSORS)) begin
                  sensor_in = '0;
                  if (round_nxt >= (zr_pkg::ROUND_W+1)'(zr_pkg::SAMPLES)) begin
                     round_in = '0;
                     phase_in = zr_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     round_in = round_nxt[zr_pkg::ROUND_W-1:0];
                     phase_in = zr_pkg::PH_TRIG;
                  end
               end else begin
                  sensor_in = sensor_nxt[zr_pkg::SENSOR_W-1:0];
                  phase_in  = zr_pkg::PH_TRIG;
               end
            end
         end
      end
   end

   // Build the item's status as seen after this step
   always_comb begin
      stage_in.valid              = item_pop;
      stage_in.ctrl.trigger_lines = (phase_in == zr_pkg::PH_TRIG) ?
                                    (4'd1 << sensor_in) : 4'd0;
      stage_in.ctrl.busy          = (phase_in != zr_pkg::PH_IDLE);
      stage_in.ctrl.done          = done;
      stage_in.clear              = clear;
      stage_in.fin                = finish;
      stage_in.fin_idx            = sensor_ff;
      stage_in.fin_count          = fin_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= zr_pkg::PH_IDLE;
         sensor_ff      <= '0;
         round_ff       <= '0;
         tick_ff        <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         sensor_ff      <= sensor_in;
         round_ff       <= round_in;
         tick_ff        <= tick_in;
         stage_ff.valid <= stage_in.valid;
      end
      // Payload of the output stage
      stage_ff.ctrl      <= stage_in.ctrl;
      stage_ff.clear     <= stage_in.clear;
      stage_ff.fin       <= stage_in.fin;
      stage_ff.fin_idx   <= stage_in.fin_idx;
      stage_ff.fin_count <= stage_in.fin_count;
   end

endmodule

/* hdl/zr_arith.sv */
// ----------------------------------------------------------------------------
// zr_arith
// Back end: converts echo counts to cm, keeps the per-sensor sums, and at the
// end of a measurement forms the averages and the zone. Four stages, no stall.
// ----------------------------------------------------------------------------
module zr_arith (
   input  logic                clock,
   input  logic                reset,
   input  zr_pkg::cfg_type     cfg,
   input  zr_pkg::stage_type   stage,
   output logic [2:0]          inflight,
   output logic                rsp_push,
   output zr_pkg::rsp_item_type rsp_item
);

   // Stage 2: distance product
   logic                                p2_valid_ff;
   zr_pkg::ctrl_type                    p2_ctrl_ff;
   logic                                p2_clear_ff;
   logic                                p2_fin_ff;
   logic [zr_pkg::SENSOR_W-1:0]         p2_idx_ff;
   logic [zr_pkg::CM_PROD_W-1:0]        p2_prod_ff;

   // Stage 3: sums updated
   logic                                p3_valid_ff;
   zr_pkg::ctrl_type                    p3_ctrl_ff;
   logic [3:0][zr_pkg::SUM_W-1:0]       sum_ff;

   // Stage 4: average products
   logic                                p4_valid_ff;
   zr_pkg::ctrl_type                    p4_ctrl_ff;
   logic [3:0][zr_pkg::AVG_PROD_W-1:0]  avg_prod_ff;

   // Stage 5: averages and zone stored
   logic                                p5_valid_ff;
   zr_pkg::ctrl_type                    p5_ctrl_ff;
   logic [3:0][zr_pkg::AVG_W-1:0]       last_avg_ff, last_avg_in;
   logic [1:0]                          zone_ff, zone_in;

   logic [zr_pkg::AVG_W-1:0]            cm_dist;
   logic [zr_pkg::SUM_W:0]              sum_add;
   logic [3:0]                          lane_near;
   logic [3:0]                          lane_far;

   assign inflight = 3'(p2_valid_ff) + 3'(p3_valid_ff) + 3'(p4_valid_ff)
                   + 3'(p5_valid_ff);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= stage.valid;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
      end
   end

   // Stage 2: half count times reciprocal of 58
   always_ff @(posedge clock) begin
      p2_ctrl_ff  <= stage.ctrl;
      p2_clear_ff <= stage.clear;
      p2_fin_ff   <= stage.fin;
      p2_idx_ff   <= stage.fin_idx;
      p2_prod_ff  <= zr_pkg::CM_PROD_W'(stage.fin_count[zr_pkg::TICK_W-1:1])
                   * zr_pkg::CM_PROD_W'(zr_pkg::CM_RECIP);
      p3_ctrl_ff  <= p2_ctrl_ff;
      p4_ctrl_ff  <= p3_ctrl_ff;
      p5_ctrl_ff  <= p4_ctrl_ff;
   end

   // Stage 3: accumulate with saturation; a start from idle clears all sums
   always_comb begin
      cm_dist = p2_prod_ff[zr_pkg::CM_SHIFT +: zr_pkg::AVG_W];
      sum_add = {1'b0, sum_ff[p2_idx_ff]}
              + (zr_pkg::SUM_W+1)'(cm_dist);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (p2_valid_ff && p2_clear_ff) begin
         sum_ff <= '0;
      end else if (p2_valid_ff && p2_fin_ff) begin
         sum_ff[p2_idx_ff] <= sum_add[zr_pkg::SUM_W] ? zr_pkg::SUM_MAX
                                                      : sum_add[zr_pkg::SUM_W-1:0];
      end
   end

   // Stage 4: sums times reciprocal of the sample count, one lane per sensor
   for (genvar i = 0; i < 4; i++) begin : g_lane
      always_ff @(posedge clock) begin
         if (p3_valid_ff && p3_ctrl_ff.done) begin
            avg_prod_ff[i] <= zr_pkg::AVG_PROD_W'(sum_ff[i])
                            * zr_pkg::AVG_PROD_W'(zr_pkg::AVG_RECIP);
         end
      end
   end

   // Stage 5: saturate, compare against limits, pick the zone
   always_comb begin
      logic [zr_pkg::AVG_Q_W-1:0] q;
      for (int i = 0; i < 4; i++) begin
         q = avg_prod_ff[i][zr_pkg::AVG_SHIFT +: zr_pkg::AVG_Q_W];
         if (i < zr_pkg::SENSORS) begin
            last_avg_in[i] = (q > zr_pkg::AVG_Q_W'(zr_pkg::AVG_MAX)) ?
                             zr_pkg::AVG_MAX : q[zr_pkg::AVG_W-1:0];
            lane_near[i]   = (last_avg_in[i] <= cfg.near_limit);
            lane_far[i]    = (last_avg_in[i] <= cfg.far_limit);
         end else begin
            last_avg_in[i] = '0;
            lane_near[i]   = 1'b0;
            lane_far[i]    = 1'b0;
         end
      end
      if (|lane_near) begin
         zone_in = zr_pkg::ZONE_NEAR;
      end else if (|lane_far) begin
         zone_in = zr_pkg::ZONE_MIDDLE;
      end else begin
         zone_in = zr_pkg::ZONE_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_avg_ff <= '0;
         zone_ff     <= zr_pkg::ZONE_CLEAR;
      end else if (p4_valid_ff && p4_ctrl_ff.done) begin
         last_avg_ff <= last_avg_in;
         zone_ff     <= zone_in;
      end
   end

   // Assemble the result item
   assign rsp_push = p5_valid_ff;
   always_comb begin
      rsp_item.trigger_lines = p5_ctrl_ff.trigger_lines;
      rsp_item.busy          = p5_ctrl_ff.busy;
      rsp_item.result_valid  = p5_ctrl_ff.done;
      rsp_item.zone          = zone_ff;
      rsp_item.average       = last_avg_ff;
   end

endmodule

/* hdl/zr_rsp_queue.sv */
// ----------------------------------------------------------------------------
// zr_rsp_queue
// Result queue: holds finished items until the consumer pops them.
// ----------------------------------------------------------------------------
module zr_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  zr_pkg::rsp_item_type push_item,
   input  logic                 pop,
   output logic                 empty,
   output zr_pkg::rsp_item_type head,
   output logic [zr_pkg::RSP_PTR_W:0] level
);

   zr_pkg::rsp_item_type          entry_ff [zr_pkg::RSP_DEPTH];
   logic [zr_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [zr_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [zr_pkg::RSP_PTR_W:0]    count_ff, count_in;
   logic                          do_pop;

   assign empty  = (count_ff == '0);
   assign head   = entry_ff[rd_ptr_ff];
   assign level  = count_ff;
   assign do_pop = pop && !empty;

   // Advance pointers; room is guaranteed by the issue check upstream
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (zr_pkg::RSP_PTR_W)'(push);
      rd_ptr_in = rd_ptr_ff + (zr_pkg::RSP_PTR_W)'(do_pop);
      count_in  = count_ff + (zr_pkg::RSP_PTR_W+1)'(push)
                           - (zr_pkg::RSP_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/zr_checker.sv */
// ----------------------------------------------------------------------------
// zr_checker
// Port-level checks of the zone ranger, attached to the top level by bind.
// ----------------------------------------------------------------------------
module zr_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  logic       pop,
   input  logic [3:0] rsp_trigger_lines,
   input  logic       rsp_busy_res,
   input  logic       rsp_result_valid,
   input  logic [1:0] rsp_zone_code
);

   // A finishing item leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_result_valid |-> !rsp_busy_res)
      else $error("result_valid shown while still busy");

   // At most one trigger line at a time
   a_trig_onehot: assert property (@(posedge clock) disable iff (reset)
      !empty |-> $onehot0(rsp_trigger_lines))
      else $error("more than one trigger line driven");

   // A trigger line is only driven during a measurement
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      !empty && (rsp_trigger_lines != 4'd0) |-> rsp_busy_res)
      else $error("trigger driven while idle");

   // Zone is never the unused code
   a_zone_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_zone_code != 2'd0))
      else $error("zone code zero");

   // A waiting item stays put until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_zone_code)
                         && $stable(rsp_trigger_lines))
      else $error("result changed while waiting");

endmodule

bind ultrasonic_zone_ranger zr_checker u_zr_checker (.*);
